[rtl/ffha_pkg.sv]
// shared constants and codes for the first-fit heap allocator
`default_nettype none
package ffha_pkg;
	localparam int HEAP_BYTES_DEF   = 1048576;
	localparam int HEADER_BYTES_DEF = 12;
	localparam int REQ_W            = 21;
	localparam int ADDR_W           = 20;
	localparam logic OP_ALLOC       = 1'b0;
	localparam logic OP_FREE        = 1'b1;
endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// Heap allocator over boundary-tagged blocks kept in one header memory, one
// entry per 4-byte word. Each request (allocate or free) gives exactly one result.
// After reset a clearing pass writes every header entry; no request is taken
// meanwhile. An allocate reads and checks one block header at a time, walking
// from the rover; a split adds steps for the remainder header and the prev-link
// update before the result is posted. For a free, a malformed address goes
// straight to the result, and a free that merges with both neighbours takes
// the longest. All work goes through the single memory port, one access per
// cycle, and one request is in flight at a time.
`default_nettype none
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         opcode,
	input  wire logic [ffha_pkg::REQ_W-1:0]   req_size,
	input  wire logic [ffha_pkg::ADDR_W-1:0]  block_addr,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              ok,
	output logic      [ffha_pkg::ADDR_W-1:0]  addr
);
	// header word: size, free flag, prev index (none marker is the depth)
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int IW    = $clog2(DEPTH);
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int SW    = $clog2(HEAP_BYTES + 1);
	localparam int EW    = SW + 1 + PW;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_addr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	// sequencer: request handshake, header walk, merge and split steps
	ffha_ctrl #(
		.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES), .DEPTH(DEPTH),
		.IW(IW), .PW(PW), .SW(SW), .EW(EW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .req_size(req_size), .block_addr(block_addr),
		.out_valid(out_valid), .out_ready(out_ready), .ok(ok), .addr(addr),
		.mem_re(mem_re), .mem_we(mem_we), .mem_addr(mem_addr),
		.mem_wdata(mem_wdata), .mem_rdata(mem_rdata)
	);

	// header store
	ffha_mem #(.DEPTH(DEPTH), .EW(EW)) u_mem (
		.clk(clk), .re(mem_re), .we(mem_we), .maddr(mem_addr),
		.wdata(mem_wdata), .rdata(mem_rdata)
	);
endmodule
`default_nettype wire

[rtl/ffha_mem.sv]
// single-port header memory with registered read data
`default_nettype none
module ffha_mem #(
	parameter int DEPTH = 262144,
	parameter int EW    = 41
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] maddr,
	input  wire logic [EW-1:0]            wdata,
	output logic      [EW-1:0]            rdata
);
	logic [EW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[maddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[maddr];
		end
	end
endmodule
`default_nettype wire

[rtl/ffha_ctrl.sv]
// sequencer that walks and edits block headers through one memory port
`default_nettype none
module ffha_ctrl #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
	parameter int DEPTH        = HEAP_BYTES / 4,
	parameter int IW           = $clog2(DEPTH),
	parameter int PW           = $clog2(DEPTH + 1),
	parameter int SW           = $clog2(HEAP_BYTES + 1),
	parameter int EW           = SW + 1 + PW
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         opcode,
	input  wire logic [ffha_pkg::REQ_W-1:0]   req_size,
	input  wire logic [ffha_pkg::ADDR_W-1:0]  block_addr,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              ok,
	output logic      [ffha_pkg::ADDR_W-1:0]  addr,
	output logic                              mem_re,
	output logic                              mem_we,
	output logic      [IW-1:0]                mem_addr,
	output logic      [EW-1:0]                mem_wdata,
	input  wire logic [EW-1:0]                mem_rdata
);
	localparam int CW = (SW + 1 > ffha_pkg::REQ_W + 1) ? SW + 1 : ffha_pkg::REQ_W + 1;
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
	localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
	localparam logic [PW-1:0] NONE_C = PW'(DEPTH);
	localparam logic [IW-1:0] LAST_C = IW'(DEPTH - 1);

	typedef enum logic [4:0] {
		S_CLR, S_INIT, S_IDLE, A_RD, A_CK, A_WRN, F_RDM, F_CKM, F_CKN, F_PV,
		F_CKP, F_CLRM, F_WRM, F_FIN, LK_RD, LK_WR, S_DONE
	} state_t;

	state_t          state_q, ret_q;
	logic [CW-1:0]   need_q, lk_byte_q;
	logic [IW-1:0]   cur_q, mm_q, old_q, rover_q, clr_q, nb_q;
	logic [SW-1:0]   sz_q;
	logic [PW-1:0]   prv_q, lk_prev_q;
	logic            ok_r_q, out_valid_q, ok_q;
	logic [ffha_pkg::ADDR_W-1:0] addr_r_q, addr_q;

	logic [SW-1:0]   rd_size;
	logic            rd_free;
	logic [PW-1:0]   rd_prev;
	logic [CW-1:0]   ba, hdr, need_in, cur_b, mm_b, fb_cur, fb_mm, nbb, rem, lk_sum, pv_b;
	logic            free_ok, fit, split;

	assign rd_size = mem_rdata[EW-1 -: SW];
	assign rd_free = mem_rdata[PW];
	assign rd_prev = mem_rdata[PW-1:0];

	assign ba      = CW'(block_addr);
	assign hdr     = ba - HDR_C;
	assign free_ok = (ba >= HDR_C) && (hdr[1:0] == 2'b00) && (hdr < HEAP_C);
	assign need_in = (CW'(req_size) + HDR_C + CW'(3)) & ~CW'(3);
	assign cur_b   = CW'({cur_q, 2'b00});
	assign mm_b    = CW'({mm_q, 2'b00});
	assign pv_b    = CW'({prv_q[IW-1:0], 2'b00});
	assign fb_cur  = cur_b + CW'(rd_size);
	assign fb_mm   = mm_b + CW'(rd_size);
	assign nbb     = cur_b + need_q;
	assign rem     = CW'(rd_size) - need_q;
	assign fit     = rd_free && (CW'(rd_size) >= need_q);
	assign split   = (rem > HDR_C) && (nbb < HEAP_C);
	assign lk_sum  = CW'(rd_size) + CW'(sz_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign addr      = addr_q;

	// memory command from the current step
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {SW'(HEAP_BYTES), 1'b1, NONE_C};
			end
			A_RD: begin
				mem_re   = 1'b1;
				mem_addr = cur_q;
			end
			A_CK: begin
				if (rd_size != '0 && fit) begin
					mem_we    = 1'b1;
					mem_addr  = cur_q;
					mem_wdata = {split ? need_q[SW-1:0] : rd_size, 1'b0, rd_prev};
				end
			end
			A_WRN: begin
				mem_we    = 1'b1;
				mem_addr  = nb_q;
				mem_wdata = {sz_q, 1'b1, PW'(cur_q)};
			end
			F_RDM: begin
				mem_re   = 1'b1;
				mem_addr = mm_q;
			end
			F_CKM: begin
				if (rd_size != '0 && !rd_free && fb_mm < HEAP_C) begin
					mem_re   = 1'b1;
					mem_addr = fb_mm[IW+1:2];
				end
			end
			F_CKN: begin
				if (rd_free) begin
					mem_we   = 1'b1;
					mem_addr = cur_q;
				end
			end
			F_PV: begin
				if (prv_q < NONE_C) begin
					mem_re   = 1'b1;
					mem_addr = prv_q[IW-1:0];
				end
			end
			F_CKP: begin
				if (rd_free && rd_size != '0) begin
					mem_we    = 1'b1;
					mem_addr  = prv_q[IW-1:0];
					mem_wdata = {lk_sum[SW-1:0], 1'b1, rd_prev};
				end
			end
			F_CLRM: begin
				mem_we   = 1'b1;
				mem_addr = old_q;
			end
			F_WRM: begin
				mem_we    = 1'b1;
				mem_addr  = mm_q;
				mem_wdata = {sz_q, 1'b1, prv_q};
			end
			LK_RD: begin
				if (lk_byte_q < HEAP_C) begin
					mem_re   = 1'b1;
					mem_addr = lk_byte_q[IW+1:2];
				end
			end
			LK_WR: begin
				mem_we    = 1'b1;
				mem_addr  = lk_byte_q[IW+1:2];
				mem_wdata = {rd_size, rd_free, lk_prev_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= S_DONE;
			clr_q       <= '0;
			rover_q     <= '0;
			out_valid_q <= 1'b0;
			ok_r_q      <= 1'b0;
			addr_r_q    <= '0;
		end else begin
			// the result step owns out_valid_q while it is active
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_C) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						ok_r_q   <= 1'b0;
						addr_r_q <= '0;
						need_q   <= need_in;
						cur_q    <= rover_q;
						mm_q     <= hdr[IW+1:2];
						if (opcode == ffha_pkg::OP_ALLOC) begin
							state_q <= A_RD;
						end else if (free_ok) begin
							state_q <= F_RDM;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				A_RD: state_q <= A_CK;
				A_CK: begin
					if (rd_size == '0) begin
						state_q <= S_DONE;
					end else if (fit) begin
						ok_r_q   <= 1'b1;
						addr_r_q <= ffha_pkg::ADDR_W'(cur_b + HDR_C);
						if (split) begin
							sz_q      <= rem[SW-1:0];
							nb_q      <= nbb[IW+1:2];
							rover_q   <= nbb[IW+1:2];
							lk_byte_q <= fb_cur;
							lk_prev_q <= PW'(nbb[IW+1:2]);
							ret_q     <= S_DONE;
							state_q   <= A_WRN;
						end else begin
							rover_q <= (fb_cur < HEAP_C) ? fb_cur[IW+1:2] : '0;
							state_q <= S_DONE;
						end
					end else if (fb_cur >= HEAP_C) begin
						state_q <= S_DONE;
					end else begin
						cur_q   <= fb_cur[IW+1:2];
						state_q <= A_RD;
					end
				end
				A_WRN: state_q <= LK_RD;
				F_RDM: state_q <= F_CKM;
				F_CKM: begin
					sz_q  <= rd_size;
					prv_q <= rd_prev;
					cur_q <= fb_mm[IW+1:2];
					if (rd_size == '0 || rd_free) begin
						state_q <= S_DONE;
					end else if (fb_mm < HEAP_C) begin
						state_q <= F_CKN;
					end else begin
						state_q <= F_PV;
					end
				end
				F_CKN: begin
					if (rd_free) begin
						sz_q      <= lk_sum[SW-1:0];
						lk_byte_q <= mm_b + lk_sum;
						lk_prev_q <= PW'(mm_q);
						ret_q     <= F_PV;
						state_q   <= LK_RD;
					end else begin
						state_q <= F_PV;
					end
				end
				F_PV: state_q <= (prv_q < NONE_C) ? F_CKP : F_WRM;
				F_CKP: begin
					if (rd_free && rd_size != '0) begin
						lk_byte_q <= pv_b + lk_sum;
						lk_prev_q <= prv_q;
						old_q     <= mm_q;
						mm_q      <= prv_q[IW-1:0];
						ret_q     <= F_FIN;
						state_q   <= F_CLRM;
					end else begin
						state_q <= F_WRM;
					end
				end
				F_CLRM: state_q <= LK_RD;
				F_WRM: state_q <= F_FIN;
				F_FIN: begin
					ok_r_q <= 1'b1;
					if (mm_q < rover_q) begin
						rover_q <= mm_q;
					end
					state_q <= S_DONE;
				end
				LK_RD: state_q <= (lk_byte_q < HEAP_C) ? LK_WR : ret_q;
				LK_WR: state_q <= ret_q;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ok_q        <= ok_r_q;
						addr_q      <= addr_r_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we)) else $error("read and write in one cycle");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (addr_q == '0)) else $error("failed result with address");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready while working");
	a_rover: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (32'(rover_q) < DEPTH)) else $error("rover out of heap");
endmodule
`default_nettype wire
